@@ hw/rtl/logic_sample_rle_encoder_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the logic sample RLE encoder
// Shared helpers that keep the clocking and reset handling of every check
// uniform.
// ----------------------------------------------------------------------------
`ifndef LOGIC_SAMPLE_RLE_ENCODER_ASSERT_SVH
`define LOGIC_SAMPLE_RLE_ENCODER_ASSERT_SVH

// Plain check, sampled on the rising clock edge and off while in reset.
`define LSRE_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("lsre check failed");

// Check that a signal holds its value while a condition is true.
`define LSRE_ASSERT_HOLD(lbl, clk, rstn, cond, sig) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> $stable(sig)) \
    else $error("lsre hold check failed");

`endif

@@ hw/rtl/lsre_pkg.sv @@
// ----------------------------------------------------------------------------
// Logic sample RLE encoder package
// Types, constants and the run word builder shared by the encoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package lsre_pkg;

  localparam int unsigned SampleW   = 16;
  localparam int unsigned WordW     = 32;
  localparam int unsigned BytesW    = 3;
  localparam int unsigned RunLenW   = 16;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 1;
  localparam int unsigned FifoDepth = 4;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] RegRleEnable  = 1'd0;
  localparam logic [CfgIdxW-1:0] RegWideSample = 1'd1;

  localparam logic [SampleW-1:0] NoRun     = 16'h8000;
  localparam logic [RunLenW-1:0] NarrowCap = 16'h0080;
  localparam logic [RunLenW-1:0] WideCap   = 16'h8000;

  localparam logic [BytesW-1:0] Bytes1 = 3'd1;
  localparam logic [BytesW-1:0] Bytes2 = 3'd2;
  localparam logic [BytesW-1:0] Bytes4 = 3'd4;

  typedef struct packed {
    logic [WordW-1:0]  word;
    logic [BytesW-1:0] bytes;
    logic              last;
  } code_t;

  typedef struct packed {
    logic [1:0]         cnt;
    code_t              res0;
    code_t              res1;
    logic [SampleW-1:0] run_value;
    logic [RunLenW-1:0] run_length;
  } core_out_t;

  // Builds a run mark word: the length minus one with the mark bit in the low
  // half of the word (wide) or of its low 16 bits (narrow), the value above it.
  function automatic logic [WordW-1:0] run_word(input logic [SampleW-1:0] val,
                                                input logic [RunLenW-1:0] len,
                                                input logic wide);
    logic [RunLenW-1:0] n;
    n = len - 16'd1;
    if (wide) begin
      run_word = {1'b0, val[14:0], 1'b1, n[14:0]};
    end else begin
      run_word = {16'h0000, 1'b0, val[6:0], 1'b1, n[6:0]};
    end
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/lsre_if.sv @@
// ----------------------------------------------------------------------------
// Logic sample RLE encoder channels
// Valid/ready channels for incoming samples and outgoing code words.
// ----------------------------------------------------------------------------
`default_nettype none

interface lsre_sample_if;
  logic        valid;
  logic        ready;
  logic [15:0] sample;
  logic        sample_last;

  modport source (output valid, output sample, output sample_last, input ready);
  modport sink   (input valid, input sample, input sample_last, output ready);
endinterface

interface lsre_code_if;
  logic        valid;
  logic        ready;
  logic [31:0] code_word;
  logic [2:0]  code_bytes;
  logic        word_last;

  modport source (output valid, output code_word, output code_bytes, output word_last,
                  input ready);
  modport sink   (input valid, input code_word, input code_bytes, input word_last,
                  output ready);
endinterface

`default_nettype wire

@@ hw/rtl/lsre_core.sv @@
// ----------------------------------------------------------------------------
// Logic sample RLE encoder step logic
// Compares one sample with the pending run and produces up to two code words
// and the next run state.
// ----------------------------------------------------------------------------
`default_nettype none

module lsre_core import lsre_pkg::*; (
  input  logic [SampleW-1:0] sample_i,
  input  logic               last_i,
  input  logic               rle_en_i,
  input  logic               wide_i,
  input  logic [SampleW-1:0] run_value_i,
  input  logic [RunLenW-1:0] run_length_i,
  output core_out_t          out_o
);

  logic [SampleW-1:0] v;
  logic [RunLenW-1:0] cap;
  logic [RunLenW-1:0] len_inc;
  logic [RunLenW-1:0] len_new;
  logic               emit_a;
  logic               emit_b;
  logic [WordW-1:0]   word_a;
  logic [WordW-1:0]   word_b;
  logic [BytesW-1:0]  run_bytes;

  always_comb begin
    v         = wide_i ? {1'b0, sample_i[14:0]} : {9'b0, sample_i[6:0]};
    cap       = wide_i ? WideCap : NarrowCap;
    run_bytes = wide_i ? Bytes4 : Bytes2;
    len_inc   = run_length_i + 16'd1;
    emit_a    = 1'b0;
    word_a    = run_word(run_value_i, run_length_i, wide_i);
    len_new   = 16'd1;

    if (v != run_value_i) begin
      // A new value closes whatever run was pending.
      emit_a = (run_length_i != '0);
    end else if (len_inc >= cap) begin
      // The run is full: send it now and keep the value.
      emit_a  = 1'b1;
      word_a  = run_word(run_value_i, cap, wide_i);
      len_new = '0;
    end else begin
      len_new = len_inc;
    end

    emit_b = last_i && (len_new != '0);
    word_b = run_word(v, len_new, wide_i);

    out_o = '0;
    if (!rle_en_i) begin
      out_o.cnt        = 2'd1;
      out_o.res0.word  = wide_i ? {16'h0000, sample_i} : {24'h000000, sample_i[7:0]};
      out_o.res0.bytes = wide_i ? Bytes2 : Bytes1;
      out_o.res0.last  = last_i;
      out_o.run_value  = last_i ? NoRun : run_value_i;
      out_o.run_length = last_i ? '0 : run_length_i;
    end else begin
      out_o.cnt        = {1'b0, emit_a} + {1'b0, emit_b};
      out_o.res0.word  = emit_a ? word_a : word_b;
      out_o.res0.bytes = run_bytes;
      out_o.res0.last  = last_i && !(emit_a && emit_b);
      out_o.res1.word  = word_b;
      out_o.res1.bytes = run_bytes;
      out_o.res1.last  = last_i;
      out_o.run_value  = last_i ? NoRun : v;
      out_o.run_length = last_i ? '0 : len_new;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/lsre_ofifo.sv @@
// ----------------------------------------------------------------------------
// Logic sample RLE encoder output queue
// Small queue: takes up to two code words a cycle, hands one out on ready_i.
// ----------------------------------------------------------------------------
`default_nettype none

module lsre_ofifo import lsre_pkg::*; #(
  parameter int unsigned Depth = FifoDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] push_cnt_i,
  input  code_t      push0_i,
  input  code_t      push1_i,
  output logic       room2_o,
  output logic       valid_o,
  input  logic       ready_i,
  output code_t      data_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  code_t             mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [PtrW-1:0]   wr_next;
  logic              pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign room2_o = (count_q <= CntW'(Depth - 2));
  assign wr_next = wr_ptr_q + PtrW'(1);

  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrW'(push_cnt_i);
    rd_ptr_d = rd_ptr_q + PtrW'(pop);
    count_d  = count_q + CntW'(push_cnt_i) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wr_ptr_q] <= push0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wr_next] <= push1_i;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/logic_sample_rle_encoder.sv @@
// ----------------------------------------------------------------------------
// Logic sample run-length encoder
// Turns a stream of captured samples into raw bytes or run mark words.
// ----------------------------------------------------------------------------
//  channel   dir  payload                               handshake
//  in_ch     in   sample[15:0], sample_last             valid/ready
//  out_ch    out  code_word[31:0], code_bytes, word_last valid/ready
//  cfg       in   cfg_idx_i, cfg_wdata_i                cfg_we_i, no wait
//
// One sample is taken per cycle while the queue has room for two more words.
// A sample waits in the input register until the queue has that room, and is
// then encoded into a four-entry output queue, from which its words go out
// on out_ch.
// A sample that yields two words needs two free queue entries; when the sink
// stalls, in_ch.ready drops once the queue cannot take two more words.
// rst_ni clears the config, the run state and the queue asynchronously.
// ----------------------------------------------------------------------------
`default_nettype none

module logic_sample_rle_encoder import lsre_pkg::*; #(
  parameter int unsigned QueueDepth = FifoDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  lsre_sample_if.sink         in_ch,
  lsre_code_if.source         out_ch,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  logic               rle_en_q;
  logic               wide_q;
  logic [SampleW-1:0] run_value_q;
  logic [RunLenW-1:0] run_length_q;
  logic [SampleW-1:0] sample_q;
  logic               last_q;
  logic               valid_q;
  logic               room2;
  logic               proc_fire;
  logic               in_fire;
  logic [1:0]         push_cnt;
  core_out_t          core_out;
  code_t              head;

  assign proc_fire   = valid_q && room2;
  assign in_ch.ready = !valid_q || proc_fire;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign push_cnt    = proc_fire ? core_out.cnt : 2'd0;

  lsre_core u_core (
    .sample_i     (sample_q),
    .last_i       (last_q),
    .rle_en_i     (rle_en_q),
    .wide_i       (wide_q),
    .run_value_i  (run_value_q),
    .run_length_i (run_length_q),
    .out_o        (core_out)
  );

  lsre_ofifo #(
    .Depth (QueueDepth)
  ) u_ofifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (push_cnt),
    .push0_i    (core_out.res0),
    .push1_i    (core_out.res1),
    .room2_o    (room2),
    .valid_o    (out_ch.valid),
    .ready_i    (out_ch.ready),
    .data_o     (head)
  );

  assign out_ch.code_word  = head.word;
  assign out_ch.code_bytes = head.bytes;
  assign out_ch.word_last  = head.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rle_en_q     <= 1'b0;
      wide_q       <= 1'b0;
      run_value_q  <= NoRun;
      run_length_q <= '0;
      valid_q      <= 1'b0;
    end else begin
      if (in_fire) begin
        valid_q <= 1'b1;
      end else if (proc_fire) begin
        valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        // Any register write drops the pending run.
        case (cfg_idx_i)
          RegRleEnable:  rle_en_q <= cfg_wdata_i[0];
          RegWideSample: wide_q   <= cfg_wdata_i[0];
          default: ;
        endcase
        run_value_q  <= NoRun;
        run_length_q <= '0;
      end else if (proc_fire) begin
        run_value_q  <= core_out.run_value;
        run_length_q <= core_out.run_length;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      sample_q <= in_ch.sample;
      last_q   <= in_ch.sample_last;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/lsre_checker.sv @@
// ----------------------------------------------------------------------------
// Logic sample RLE encoder port checks
// Watches the output channel of the encoder and checks word formats.
// ----------------------------------------------------------------------------
`default_nettype none

`include "logic_sample_rle_encoder_assert.svh"

module lsre_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_word_i,
  input logic [2:0]  out_bytes_i
);

  // A stalled word must not change under the sink.
  `LSRE_ASSERT_HOLD(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_word_i)

  `LSRE_ASSERT(a_bytes_legal, clk_i, rst_ni,
    out_valid_i |-> (out_bytes_i == 3'd1 || out_bytes_i == 3'd2 || out_bytes_i == 3'd4))

  // Wide run words always carry the mark bit and a cleared top bit.
  `LSRE_ASSERT(a_wide_run_mark, clk_i, rst_ni,
    (out_valid_i && out_bytes_i == 3'd4) |-> (out_word_i[15] && !out_word_i[31]))

  // Narrow raw bytes never carry data above the low byte.
  `LSRE_ASSERT(a_narrow_raw, clk_i, rst_ni,
    (out_valid_i && out_bytes_i == 3'd1) |-> (out_word_i[31:8] == 24'h000000))

endmodule

bind logic_sample_rle_encoder lsre_checker u_lsre_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_ch.valid),
  .out_ready_i (out_ch.ready),
  .out_word_i  (out_ch.code_word),
  .out_bytes_i (out_ch.code_bytes)
);

`default_nettype wire

@@ bench/tb_logic_sample_rle_encoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the logic sample run-length encoder
// Drives sample items through the valid/ready input channel under every
// register setting and checks each code word against a cycle-free predictor
// of the encoding, with random gaps on the source and stalls on the sink.
// ----------------------------------------------------------------------------

module tb_logic_sample_rle_encoder;
  import lsre_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned PhaseItems    = 120;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  lsre_sample_if in_ch ();
  lsre_code_if   out_ch ();

  logic_sample_rle_encoder uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  // Predictor state.
  logic               rle_on;
  logic               wide_on;
  logic [SampleW-1:0] cur_value;
  logic [RunLenW-1:0] cur_len;
  code_t              pending_codes[$];

  int unsigned error_count = 0;
  int unsigned sent_items  = 0;
  int unsigned quiet_cycles = 0;
  bit          src_idle = 1'b1;
  bit          sink_idle = 1'b1;

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 15) begin
      return $urandom_range(1, 3);
    end else if (r < 19) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 40);
  endfunction

  function automatic void drop_run();
    cur_value = NoRun;
    cur_len   = '0;
  endfunction

  function automatic code_t make_run_code();
    code_t              c;
    logic [RunLenW-1:0] n;
    n = cur_len - 16'd1;
    if (wide_on) begin
      c.word  = {1'b0, cur_value[14:0], 1'b1, n[14:0]};
      c.bytes = Bytes4;
    end else begin
      c.word  = {16'h0000, 1'b0, cur_value[6:0], 1'b1, n[6:0]};
      c.bytes = Bytes2;
    end
    c.last = 1'b0;
    return c;
  endfunction

  // Works out the code words that one accepted sample item causes.
  function automatic void encode_sample(input logic [SampleW-1:0] s, input logic last);
    code_t              codes[2];
    int                 n;
    logic [SampleW-1:0] v;
    logic [RunLenW-1:0] cap;
    n = 0;
    if (!rle_on) begin
      codes[0].word  = wide_on ? {16'h0000, s} : {24'h000000, s[7:0]};
      codes[0].bytes = wide_on ? Bytes2 : Bytes1;
      codes[0].last  = 1'b0;
      n = 1;
      if (last) drop_run();
    end else begin
      v   = wide_on ? {1'b0, s[14:0]} : {9'h000, s[6:0]};
      cap = wide_on ? WideCap : NarrowCap;
      if (v != cur_value) begin
        if (cur_len > 0) begin
          codes[n] = make_run_code();
          n++;
        end
        cur_value = v;
        cur_len   = 16'd1;
      end else begin
        cur_len = cur_len + 16'd1;
        if (cur_len >= cap) begin
          cur_len  = cap;
          codes[n] = make_run_code();
          n++;
          cur_len  = '0;
        end
      end
      if (last) begin
        if (cur_len > 0) begin
          codes[n] = make_run_code();
          n++;
        end
        drop_run();
      end
    end
    if (last && n > 0) codes[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) pending_codes.push_back(codes[i]);
  endfunction

  task automatic send_sample(input logic [SampleW-1:0] s, input logic last);
    if (src_idle && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap_len()) @(posedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.sample      <= s;
    in_ch.sample_last <= last;
    do @(posedge clk_i); while (!in_ch.ready);
    encode_sample(s, last);
    sent_items++;
  endtask

  // Waits until every expected word has come, then lets the pipeline settle,
  // since a sample inside a run causes no word at all.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_codes.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_register(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    if (idx == RegRleEnable) begin
      rle_on = data[0];
    end else if (idx == RegWideSample) begin
      wide_on = data[0];
    end
    drop_run();
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure(input logic rle, input logic wide);
    wait_idle();
    if ($urandom_range(0, 1) == 1) begin
      set_register(RegRleEnable, rle);
      set_register(RegWideSample, wide);
    end else begin
      set_register(RegWideSample, wide);
      set_register(RegRleEnable, rle);
    end
  endtask

  task automatic test_raw_passthrough();
    for (int w = 0; w < 2; w++) begin
      configure(1'b0, w[0]);
      send_sample(16'h0000, 1'b0);
      send_sample(16'hffff, 1'b0);
      send_sample(16'h00ff, 1'b0);
      send_sample(16'hff00, 1'b1);
    end
  endtask

  task automatic test_narrow_runs();
    configure(1'b1, 1'b0);
    // Bits 15:7 are dropped, so the first three items form one run.
    send_sample(16'h0000, 1'b0);
    send_sample(16'h0080, 1'b0);
    send_sample(16'hff00, 1'b0);
    send_sample(16'h007f, 1'b0);
    send_sample(16'hffff, 1'b0);
    send_sample(16'h0055, 1'b1);
    // A lone last sample still closes with a single word.
    send_sample(16'h002a, 1'b1);
  endtask

  task automatic test_wide_runs();
    configure(1'b1, 1'b1);
    send_sample(16'h0000, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h7fff, 1'b0);
    send_sample(16'hffff, 1'b0);
    send_sample(16'h1234, 1'b1);
  endtask

  task automatic test_write_drops_run();
    configure(1'b1, 1'b0);
    repeat (3) send_sample(16'h0011, 1'b0);
    wait_idle();
    set_register(RegRleEnable, 1'b1);
    send_sample(16'h0011, 1'b1);
  endtask

  task automatic test_run_caps();
    configure(1'b1, 1'b0);
    // A run that hits the cap on the last sample leaves nothing to flush.
    for (int i = 0; i < 128; i++) begin
      send_sample(16'h0033 | (16'($urandom()) & 16'hff80), i == 127);
    end
    for (int i = 0; i < 130; i++) send_sample(16'h0044, 1'b0);
    send_sample(16'h0045, 1'b1);
  endtask

  task automatic send_dump(input int runs);
    logic [SampleW-1:0] vals[3];
    logic [SampleW-1:0] keep;
    logic [SampleW-1:0] s;
    int                 len;
    int                 pick;
    int unsigned        r;
    for (int i = 0; i < 3; i++) vals[i] = 16'($urandom());
    keep = wide_on ? 16'h7fff : 16'h007f;
    for (int k = 0; k < runs; k++) begin
      pick = $urandom_range(0, 2);
      r = $urandom_range(0, 99);
      if (r < 65) begin
        len = $urandom_range(1, 4);
      end else if (r < 90) begin
        len = $urandom_range(5, 20);
      end else if (r < 97) begin
        len = wide_on ? $urandom_range(30, 80) : $urandom_range(120, 135);
      end else begin
        len = wide_on ? $urandom_range(80, 120) : $urandom_range(250, 260);
      end
      for (int j = 0; j < len; j++) begin
        s = (vals[pick] & keep) | (16'($urandom()) & ~keep);
        send_sample(s, (k == runs - 1) && (j == len - 1));
      end
    end
  endtask

  task automatic test_random_streams();
    logic [1:0]  settings[8];
    int unsigned start;
    settings = '{2'b00, 2'b11, 2'b10, 2'b01, 2'b11, 2'b10, 2'b11, 2'b10};
    for (int p = 0; p < 8; p++) begin
      configure(settings[p][1], settings[p][0]);
      src_idle  = (p != 3 && p != 6);
      sink_idle = (p != 3 && p != 6);
      start = sent_items;
      while (sent_items - start < PhaseItems) begin
        if (!rle_on) begin
          send_sample(16'($urandom()), $urandom_range(0, 9) == 0);
        end else if ($urandom_range(0, 99) < 85) begin
          send_dump($urandom_range(1, 8));
        end else begin
          send_sample(16'($urandom()), $urandom_range(0, 7) == 0);
        end
      end
    end
    src_idle  = 1'b1;
    sink_idle = 1'b1;
  endtask

  // Sink side: random stalls on the output channel.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (sink_idle && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap_len()) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    code_t exp_code;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_codes.size() == 0) begin
        $error("unexpected code word %h", out_ch.code_word);
        error_count++;
      end else begin
        exp_code = pending_codes.pop_front();
        if (out_ch.code_word !== exp_code.word) begin
          $error("code_word expected %h actual %h", exp_code.word, out_ch.code_word);
          error_count++;
        end
        if (out_ch.code_bytes !== exp_code.bytes) begin
          $error("code_bytes expected %0d actual %0d", exp_code.bytes, out_ch.code_bytes);
          error_count++;
        end
        if (out_ch.word_last !== exp_code.last) begin
          $error("word_last expected %0b actual %0b", exp_code.last, out_ch.word_last);
          error_count++;
        end
      end
    end
  end

  // Ends the run when no item moves on either channel for too long.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni            = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.sample      = '0;
    in_ch.sample_last = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = '0;
    cfg_wdata_i       = '0;
    rle_on            = 1'b0;
    wide_on           = 1'b0;
    drop_run();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_raw_passthrough();
    test_narrow_runs();
    test_wide_runs();
    test_write_drops_run();
    test_run_caps();
    test_random_streams();
    wait_idle();

    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/lsre_pkg.sv
hw/rtl/lsre_if.sv
hw/rtl/lsre_core.sv
hw/rtl/lsre_ofifo.sv
hw/rtl/logic_sample_rle_encoder.sv
hw/rtl/lsre_checker.sv
bench/tb_logic_sample_rle_encoder.sv
